/* hdl/gbd_pkg.sv */
// Shared types, constants and helper functions of the gray box downscaler.
package gbd_pkg;

	// Accumulator geometry.
	localparam int MAX_DEST_WIDTH = 64;
	localparam int COL_AW = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
	localparam int SUM_W = 24;
	localparam int CNT_W = 16;
	localparam int ENTRY_W = SUM_W + CNT_W;
	localparam int DIVD_W = SUM_W + 1;
	localparam int COORD_W = 17;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [15:0] SCALE_CAP = 16'h8000;
	localparam logic [15:0] DOWN_LIMIT = 16'd4092;

	// Luma weights, sum of 128.
	localparam logic [7:0] W_RED = 8'd38;
	localparam logic [7:0] W_GREEN = 8'd75;
	localparam logic [7:0] W_BLUE = 8'd15;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_DEST_WIDTH = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PX1,
		ST_PX2,
		ST_DEC,
		ST_FL_SCAN,
		ST_FL_DATA,
		ST_FL_DIV,
		ST_FL_EMIT,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_REP
	} state_t;

	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [6:0]  dest_width;
		logic [15:0] scale_x;
		logic [15:0] scale_y;
	} cfg_t;

	typedef struct packed {
		logic [11:0] src_x;
		logic [11:0] src_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
	} pix_in_t;

	typedef struct packed {
		logic [7:0]         gray;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] y1;
		logic               idx_ok;
		logic [COL_AW-1:0]  idx;
		logic               down;
	} px_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] quot;
	} div_rsp_t;

	// Number of active accumulator columns.
	function automatic logic [6:0] columns(input logic [6:0] dw);
		logic [6:0] r;
		r = dw;
		if (32'(dw) > MAX_DEST_WIDTH) begin
			r = 7'(MAX_DEST_WIDTH);
		end
		return r;
	endfunction

	// Scale limited to 8.0 in Q4.12.
	function automatic logic [15:0] cap_scale(input logic [15:0] s);
		return s[15] ? SCALE_CAP : s;
	endfunction

endpackage

/* hdl/gbd_ram.sv */
// Generic single-port RAM with a registered read.
module gbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; read returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* hdl/gbd_div.sv */
// Restoring divider producing the eight-bit rounded column average.
module gbd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gbd_pkg::div_req_t req,
	output gbd_pkg::div_rsp_t rsp
);

	logic [gbd_pkg::DIVD_W-1:0] rem_q;
	logic [gbd_pkg::CNT_W-1:0]  dsr_q;
	logic [2:0]                 k_q;
	logic [7:0]                 quot_q;
	logic                       busy_q;
	logic                       done_q;
	logic [gbd_pkg::DIVD_W:0]   shifted;
	logic                       ge;

	// Trial subtraction of the divisor shifted to the current quotient bit.
	always_comb begin
		shifted = (gbd_pkg::DIVD_W + 1)'(dsr_q) << k_q;
		ge = {1'b0, rem_q} >= shifted;
	end

	// Control of the eight iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q <= 3'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			k_q <= 3'd7;
		end else if (busy_q) begin
			k_q <= k_q - 3'd1;
			if (k_q == 3'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsr_q <= req.divisor;
			quot_q <= 8'd0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - shifted[gbd_pkg::DIVD_W-1:0];
			end
			quot_q <= {quot_q[6:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

/* hdl/gbd_pixel.sv */
// Two-stage pixel datapath: gray level, alpha blend and scaled coordinates.
module gbd_pixel (
	input  logic             clk,
	input  gbd_pkg::pix_in_t pix,
	input  gbd_pkg::cfg_t    cfg,
	output gbd_pkg::px_t     px
);

	logic [14:0] luma_sum;
	logic [7:0]  luma;
	logic [15:0] cap_x;
	logic [15:0] cap_y;
	logic [28:0] px0_prod;
	logic [28:0] px1_prod;
	logic [28:0] py0_prod;
	logic [28:0] py1_prod;

	logic [7:0]  luma_s1;
	logic [15:0] blend_s1;
	logic [15:0] white_s1;
	logic        opaque_s1;
	logic [16:0] sx0_s1;
	logic [16:0] sx1_s1;
	logic [16:0] sy0_s1;
	logic [16:0] sy1_s1;
	logic        down_s1;

	logic [16:0] mix;
	logic [16:0] mix_div;
	logic [16:0] x0;
	logic [16:0] x1r;
	logic [16:0] y0;
	logic [16:0] y1r;
	logic [6:0]  cols;

	// Stage one: luma, blend product and the four scaled positions.
	always_comb begin
		luma_sum = 15'(pix.red) * 15'(gbd_pkg::W_RED) + 15'(pix.green) * 15'(gbd_pkg::W_GREEN)
			+ 15'(pix.blue) * 15'(gbd_pkg::W_BLUE);
		luma = luma_sum[14:7];
		cap_x = gbd_pkg::cap_scale(cfg.scale_x);
		cap_y = gbd_pkg::cap_scale(cfg.scale_y);
		px0_prod = 29'(pix.src_x) * 29'(cap_x);
		px1_prod = (29'(pix.src_x) + 29'd1) * 29'(cap_x);
		py0_prod = 29'(pix.src_y) * 29'(cap_y);
		py1_prod = (29'(pix.src_y) + 29'd1) * 29'(cap_y);
	end

	always_ff @(posedge clk) begin
		luma_s1 <= luma;
		blend_s1 <= 16'(luma) * 16'(pix.alpha);
		white_s1 <= 16'(gbd_pkg::ALPHA_OPAQUE) * 16'(gbd_pkg::ALPHA_OPAQUE - pix.alpha);
		opaque_s1 <= pix.alpha == gbd_pkg::ALPHA_OPAQUE;
		sx0_s1 <= px0_prod[28:12];
		sx1_s1 <= px1_prod[28:12];
		sy0_s1 <= py0_prod[28:12];
		sy1_s1 <= py1_prod[28:12];
		down_s1 <= (cap_x < gbd_pkg::DOWN_LIMIT) || (cap_y < gbd_pkg::DOWN_LIMIT);
	end

	// Stage two: divide the blend by 255 and place the block on screen.
	always_comb begin
		mix = 17'(blend_s1) + 17'(white_s1);
		mix_div = (mix + 17'd1 + (mix >> 8)) >> 8;
		x0 = 17'(cfg.origin_x) + sx0_s1;
		x1r = 17'(cfg.origin_x) + sx1_s1;
		y0 = 17'(cfg.origin_y) + sy0_s1;
		y1r = 17'(cfg.origin_y) + sy1_s1;
		cols = gbd_pkg::columns(cfg.dest_width);
	end

	always_ff @(posedge clk) begin
		px.gray <= opaque_s1 ? luma_s1 : mix_div[7:0];
		px.x0 <= x0;
		px.x1 <= (x1r <= x0) ? x0 + 17'd1 : x1r;
		px.y0 <= y0;
		px.y1 <= (y1r <= y0) ? y0 + 17'd1 : y1r;
		px.idx_ok <= sx0_s1 < 17'(cols);
		px.idx <= sx0_s1[gbd_pkg::COL_AW-1:0];
		px.down <= down_s1;
	end

endmodule

/* hdl/gray_box_downscaler_top.sv */
// Top level of the gray box downscaler: sequencer, column store and output register.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | mode, src_x, src_y, red, green, blue, alpha
//  out     | out_valid/ out_stall | screen_x, screen_y, gray, last
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// A pixel passes through ST_PX1 and ST_PX2 to its decision in ST_DEC, then through ST_ACC_RD
// and ST_ACC_WR for the column read-modify-write through the single RAM port, or emits
// one replicated pixel per cycle while the output is not stalled.
// A row flush walks all 64 column entries, one a cycle, and each column with a nonzero count
// also passes through RAM read and divider load, eight divider iterations, the done
// and the emit.
// Reset clears the column valid bits at once; no clearing pass is run.
// A stalled output holds the sequencer in its emit state; a new input and a
// configuration write are taken only when the sequencer is idle.
module gray_box_downscaler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [11:0] src_x,
	input  logic [11:0] src_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] screen_x,
	output logic [15:0] screen_y,
	output logic [7:0]  gray,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int MW = gbd_pkg::MAX_DEST_WIDTH;
	localparam int AW = gbd_pkg::COL_AW;

	gbd_pkg::state_t  state_q;
	gbd_pkg::state_t  state_d;
	gbd_pkg::cfg_t    cfg_q;
	gbd_pkg::pix_in_t pix_q;
	gbd_pkg::px_t     px;
	gbd_pkg::div_req_t div_req;
	gbd_pkg::div_rsp_t div_rsp;

	logic                        mode_q;
	logic                        pend_v_q;
	logic [15:0]                 pend_row_q;
	logic [MW-1:0]               vld_q;
	logic [MW-1:0]               rem_q;
	logic [MW-1:0]               col_mask;
	logic [MW-1:0]               col_bit;
	logic [AW-1:0]               col_q;
	logic                        col_end;
	logic                        rdv_q;
	logic [gbd_pkg::COORD_W-1:0] xx_q;
	logic [gbd_pkg::COORD_W-1:0] yy_q;
	logic                        rep_xlast;
	logic                        rep_last;
	logic                        ov_q;
	logic                        out_free;
	logic                        emit;
	logic                        in_acc;
	logic                        row_change;
	logic                        fl_last;
	logic [6:0]                  cols;

	logic                        ram_we;
	logic [AW-1:0]               ram_addr;
	logic [gbd_pkg::ENTRY_W-1:0] ram_wdata;
	logic [gbd_pkg::ENTRY_W-1:0] ram_rdata;
	logic [gbd_pkg::SUM_W-1:0]   old_sum;
	logic [gbd_pkg::CNT_W-1:0]   old_cnt;

	gbd_ram #(
		.WIDTH(gbd_pkg::ENTRY_W),
		.DEPTH(MW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	gbd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	gbd_pixel u_pixel (
		.clk(clk),
		.pix(pix_q),
		.cfg(cfg_q),
		.px (px)
	);

	// Helper terms for the sequencer.
	always_comb begin
		cols = gbd_pkg::columns(cfg_q.dest_width);
		for (int i = 0; i < MW; i++) begin
			col_mask[i] = i < 32'(cols);
		end
		col_bit = MW'(1) << col_q;
		col_end = col_q == AW'(MW - 1);
		fl_last = (rem_q & ~col_bit) == '0;
		row_change = pend_v_q && (pend_row_q != px.y0[15:0]);
		rep_xlast = xx_q == px.x1 - 17'd1;
		rep_last = rep_xlast && (yy_q == px.y1 - 17'd1);
		out_free = !ov_q || !out_stall;
		in_acc = in_valid && !in_stall;
		old_sum = rdv_q ? ram_rdata[gbd_pkg::ENTRY_W-1:gbd_pkg::CNT_W] : '0;
		old_cnt = rdv_q ? ram_rdata[gbd_pkg::CNT_W-1:0] : '0;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbd_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = gbd_pkg::ST_PX1;
				end
			end
			gbd_pkg::ST_PX1: state_d = gbd_pkg::ST_PX2;
			gbd_pkg::ST_PX2: state_d = gbd_pkg::ST_DEC;
			gbd_pkg::ST_DEC: begin
				if (mode_q) begin
					state_d = pend_v_q ? gbd_pkg::ST_FL_SCAN : gbd_pkg::ST_IDLE;
				end else if (px.down) begin
					state_d = row_change ? gbd_pkg::ST_FL_SCAN : gbd_pkg::ST_ACC_RD;
				end else begin
					state_d = gbd_pkg::ST_REP;
				end
			end
			gbd_pkg::ST_FL_SCAN: begin
				if (rem_q[col_q]) begin
					state_d = gbd_pkg::ST_FL_DATA;
				end else if (col_end) begin
					state_d = mode_q ? gbd_pkg::ST_IDLE : gbd_pkg::ST_ACC_RD;
				end
			end
			gbd_pkg::ST_FL_DATA: state_d = gbd_pkg::ST_FL_DIV;
			gbd_pkg::ST_FL_DIV: begin
				if (div_rsp.done) begin
					state_d = gbd_pkg::ST_FL_EMIT;
				end
			end
			gbd_pkg::ST_FL_EMIT: begin
				if (out_free) begin
					if (col_end) begin
						state_d = mode_q ? gbd_pkg::ST_IDLE : gbd_pkg::ST_ACC_RD;
					end else begin
						state_d = gbd_pkg::ST_FL_SCAN;
					end
				end
			end
			gbd_pkg::ST_ACC_RD: begin
				state_d = px.idx_ok ? gbd_pkg::ST_ACC_WR : gbd_pkg::ST_IDLE;
			end
			gbd_pkg::ST_ACC_WR: state_d = gbd_pkg::ST_IDLE;
			gbd_pkg::ST_REP: begin
				if (out_free && rep_last) begin
					state_d = gbd_pkg::ST_IDLE;
				end
			end
			default: state_d = gbd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshakes, RAM port, divider start and emission.
	always_comb begin
		in_stall = state_q != gbd_pkg::ST_IDLE;
		cfg_ready = state_q == gbd_pkg::ST_IDLE;
		ram_we = 1'b0;
		ram_addr = col_q;
		ram_wdata = {old_sum + gbd_pkg::SUM_W'(px.gray), old_cnt + gbd_pkg::CNT_W'(1)};
		div_req.start = state_q == gbd_pkg::ST_FL_DATA;
		div_req.dividend = gbd_pkg::DIVD_W'(ram_rdata[gbd_pkg::ENTRY_W-1:gbd_pkg::CNT_W])
			+ gbd_pkg::DIVD_W'(ram_rdata[gbd_pkg::CNT_W-1:1]);
		div_req.divisor = ram_rdata[gbd_pkg::CNT_W-1:0];
		emit = 1'b0;
		case (state_q)
			gbd_pkg::ST_ACC_RD: ram_addr = px.idx;
			gbd_pkg::ST_ACC_WR: begin
				ram_addr = px.idx;
				ram_we = old_cnt != gbd_pkg::CNT_MAX;
			end
			gbd_pkg::ST_FL_EMIT: emit = out_free;
			gbd_pkg::ST_REP: emit = out_free;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbd_pkg::ST_IDLE;
			cfg_q.origin_x <= 12'd0;
			cfg_q.origin_y <= 12'd0;
			cfg_q.dest_width <= 7'd64;
			cfg_q.scale_x <= 16'd4096;
			cfg_q.scale_y <= 16'd4096;
			pend_v_q <= 1'b0;
			pend_row_q <= 16'd0;
			vld_q <= '0;
			rem_q <= '0;
			col_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Configuration write transaction.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gbd_pkg::REG_ORIGIN_X: cfg_q.origin_x <= cfg_data[11:0];
					gbd_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data[11:0];
					gbd_pkg::REG_DEST_WIDTH: cfg_q.dest_width <= cfg_data[6:0];
					gbd_pkg::REG_SCALE_X: cfg_q.scale_x <= cfg_data;
					gbd_pkg::REG_SCALE_Y: cfg_q.scale_y <= cfg_data;
					default: ;
				endcase
			end

			// Flush start snapshots the active columns and empties the store.
			if (state_q == gbd_pkg::ST_DEC && state_d == gbd_pkg::ST_FL_SCAN) begin
				rem_q <= vld_q & col_mask;
				vld_q <= '0;
				col_q <= '0;
			end

			if (state_q == gbd_pkg::ST_FL_SCAN && !rem_q[col_q] && !col_end) begin
				col_q <= col_q + AW'(1);
			end

			if (state_q == gbd_pkg::ST_FL_EMIT && out_free) begin
				rem_q <= rem_q & ~col_bit;
				if (!col_end) begin
					col_q <= col_q + AW'(1);
				end
			end

			// End of image closes the pending row once it is flushed.
			if (mode_q && state_d == gbd_pkg::ST_IDLE
				&& (state_q == gbd_pkg::ST_DEC || state_q == gbd_pkg::ST_FL_SCAN
				|| state_q == gbd_pkg::ST_FL_EMIT)) begin
				pend_v_q <= 1'b0;
			end

			if (state_q == gbd_pkg::ST_ACC_RD) begin
				pend_v_q <= 1'b1;
				pend_row_q <= px.y0[15:0];
			end

			if (ram_we) begin
				vld_q[px.idx] <= 1'b1;
			end

			// Output register.
			if (emit) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			pix_q.src_x <= src_x;
			pix_q.src_y <= src_y;
			pix_q.red <= red;
			pix_q.green <= green;
			pix_q.blue <= blue;
			pix_q.alpha <= alpha;
		end
		if (state_q == gbd_pkg::ST_ACC_RD) begin
			rdv_q <= vld_q[px.idx];
		end
		if (state_q == gbd_pkg::ST_DEC) begin
			xx_q <= px.x0;
			yy_q <= px.y0;
		end else if (state_q == gbd_pkg::ST_REP && out_free) begin
			if (rep_xlast) begin
				xx_q <= px.x0;
				yy_q <= yy_q + 17'd1;
			end else begin
				xx_q <= xx_q + 17'd1;
			end
		end
		if (emit) begin
			if (state_q == gbd_pkg::ST_FL_EMIT) begin
				screen_x <= 16'(cfg_q.origin_x) + 16'(col_q);
				screen_y <= pend_row_q;
				gray <= div_rsp.quot;
				last <= fl_last;
			end else begin
				screen_x <= xx_q[15:0];
				screen_y <= yy_q[15:0];
				gray <= px.gray;
				last <= rep_last;
			end
		end
	end

	assign out_valid = ov_q;

	// The divider is never left running once the sequencer is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbd_pkg::ST_IDLE |-> !div_rsp.busy)
		else $error("divider busy while idle");

	// Every flushed column has been emitted when the sequencer returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbd_pkg::ST_IDLE |-> rem_q == '0)
		else $error("flush left columns unsent");

	// A column write always follows its own read cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q) == gbd_pkg::ST_ACC_RD)
		else $error("column write without a preceding read");

endmodule

/* bench/tb_gray_box_downscaler_top.sv */
// Self-checking testbench of the gray box downscaler: directed tests and random images.
`timescale 1ns / 1ps

module tb_gray_box_downscaler_top;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_END = 1'b1;
	localparam int SETTLE_CYCLES = 1000;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  g;
		logic        last;
	} draw_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [11:0] src_x;
	logic [11:0] src_y;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic out_valid;
	logic out_stall;
	logic [15:0] screen_x;
	logic [15:0] screen_y;
	logic [7:0] gray;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// Expected draws in order, and the draws of the transaction being predicted.
	draw_t draw_q[$];
	draw_t burst[$];
	int errors = 0;
	bit no_idle;
	int idle_count = 0;

	// Predictor copy of configuration and column store.
	int unsigned m_origin_x, m_origin_y, m_dest_width, m_scale_x, m_scale_y;
	int unsigned col_sum[gbd_pkg::MAX_DEST_WIDTH];
	int unsigned col_cnt[gbd_pkg::MAX_DEST_WIDTH];
	bit row_open;
	int unsigned open_row;

	gray_box_downscaler_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .src_x(src_x), .src_y(src_y),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.out_valid(out_valid), .out_stall(out_stall),
		.screen_x(screen_x), .screen_y(screen_y), .gray(gray), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned capped_scale(int unsigned s);
		return (s > 32768) ? 32768 : s;
	endfunction

	function automatic int unsigned scale_coord(int unsigned v, int unsigned s);
		return (v * capped_scale(s)) >> 12;
	endfunction

	function automatic int unsigned active_columns();
		return (m_dest_width > gbd_pkg::MAX_DEST_WIDTH) ? gbd_pkg::MAX_DEST_WIDTH
			: m_dest_width;
	endfunction

	function automatic void add_draw(int unsigned x, int unsigned y, int unsigned g);
		draw_t d;
		if (burst.size() < 64) begin
			d.x = x[15:0];
			d.y = y[15:0];
			d.g = g[7:0];
			d.last = 1'b0;
			burst.push_back(d);
		end
	endfunction

	// Emits rounded column averages of the open row and clears the store.
	function automatic void flush_row();
		int unsigned c;
		for (int i = 0; i < gbd_pkg::MAX_DEST_WIDTH; i++) begin
			c = col_cnt[i];
			if (c != 0 && i < active_columns())
				add_draw(m_origin_x + i, open_row, (col_sum[i] + c / 2) / c);
			col_sum[i] = 0;
			col_cnt[i] = 0;
		end
	endfunction

	// Works out the draws caused by one accepted transaction.
	function automatic void predict_draws(logic m, int unsigned sx, int unsigned sy,
			int unsigned r, int unsigned g, int unsigned b, int unsigned a);
		int unsigned lum, x0, y0, x1, y1, idx;
		draw_t d;
		burst.delete();
		if (m == MODE_END) begin
			if (row_open)
				flush_row();
			row_open = 1'b0;
		end else begin
			lum = (r * 38 + g * 75 + b * 15) >> 7;
			if (a < 255)
				lum = (lum * a + 255 * (255 - a)) / 255;
			x0 = m_origin_x + scale_coord(sx, m_scale_x);
			y0 = m_origin_y + scale_coord(sy, m_scale_y);
			if (capped_scale(m_scale_x) < 4092 || capped_scale(m_scale_y) < 4092) begin
				idx = scale_coord(sx, m_scale_x);
				if (!row_open || open_row != y0) begin
					if (row_open)
						flush_row();
					open_row = y0 & 16'hFFFF;
					row_open = 1'b1;
				end
				if (idx < active_columns() && col_cnt[idx] < 16'hFFFF) begin
					col_sum[idx] += lum;
					col_cnt[idx] += 1;
				end
			end else begin
				x1 = m_origin_x + scale_coord(sx + 1, m_scale_x);
				y1 = m_origin_y + scale_coord(sy + 1, m_scale_y);
				if (x1 <= x0)
					x1 = x0 + 1;
				if (y1 <= y0)
					y1 = y0 + 1;
				for (int unsigned yy = y0; yy < y1; yy++)
					for (int unsigned xx = x0; xx < x1; xx++)
						add_draw(xx, yy, lum);
			end
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i]) begin
			d = burst[i];
			draw_q.push_back(d);
		end
	endfunction

	// Sends one transaction; valid stays high so that a following send continues it.
	task automatic send_item(logic m, int unsigned sx, int unsigned sy,
			int unsigned r, int unsigned g, int unsigned b, int unsigned a);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		src_x <= sx[11:0];
		src_y <= sy[11:0];
		red <= r[7:0];
		green <= g[7:0];
		blue <= b[7:0];
		alpha <= a[7:0];
		do @(posedge clk); while (in_stall);
		predict_draws(m, sx, sy, r, g, b, a);
	endtask

	task automatic send_random_pixel(int unsigned sx, int unsigned sy);
		send_item(MODE_PIXEL, sx, sy, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), ($urandom_range(0, 1)) ? 255 : $urandom_range(0, 255));
	endtask

	// Waits until every expected draw has arrived and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (draw_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(gbd_pkg::cfg_reg_t idx, int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			gbd_pkg::REG_ORIGIN_X: m_origin_x = value & 12'hFFF;
			gbd_pkg::REG_ORIGIN_Y: m_origin_y = value & 12'hFFF;
			gbd_pkg::REG_DEST_WIDTH: m_dest_width = value & 7'h7F;
			gbd_pkg::REG_SCALE_X: m_scale_x = value & 16'hFFFF;
			gbd_pkg::REG_SCALE_Y: m_scale_y = value & 16'hFFFF;
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned ox, int unsigned oy, int unsigned dw,
			int unsigned scx, int unsigned scy);
		write_reg(gbd_pkg::REG_ORIGIN_X, ox);
		write_reg(gbd_pkg::REG_ORIGIN_Y, oy);
		write_reg(gbd_pkg::REG_DEST_WIDTH, dw);
		write_reg(gbd_pkg::REG_SCALE_X, scx);
		write_reg(gbd_pkg::REG_SCALE_Y, scy);
	endtask

	// Pixel extremes at reset configuration, plus an end of image with nothing open.
	task automatic test_reset_defaults();
		send_item(MODE_PIXEL, 0, 0, 0, 0, 0, 255);
		send_item(MODE_PIXEL, 4095, 4095, 255, 255, 255, 255);
		send_item(MODE_PIXEL, 2730, 1365, 255, 0, 0, 0);
		send_item(MODE_PIXEL, 1365, 2730, 0, 255, 0, 254);
		send_item(MODE_PIXEL, 7, 9, 0, 0, 255, 128);
		send_item(MODE_END, 4095, 4095, 255, 255, 255, 255);
		settle();
	endtask

	// Replication at the largest and at clamped scales, and at the mode boundary.
	task automatic test_replicate_scales();
		configure(4095, 4095, 127, 32768, 32768);
		send_item(MODE_PIXEL, 4095, 4095, 200, 100, 50, 255);
		send_item(MODE_PIXEL, 3, 5, 10, 20, 30, 1);
		settle();
		configure(100, 200, 64, 16'hFFFF, 4092);
		send_item(MODE_PIXEL, 0, 0, 90, 90, 90, 255);
		send_item(MODE_PIXEL, 1, 4095, 255, 255, 255, 0);
		settle();
	endtask

	// Row averaging, dropped columns, zero scale and a replicate pixel mid row.
	task automatic test_downscale();
		configure(10, 20, 3, 2048, 2048);
		for (int yy = 0; yy < 3; yy++)
			for (int xx = 0; xx < 8; xx++)
				send_random_pixel(xx, yy);
		send_item(MODE_END, 0, 0, 0, 0, 0, 0);
		send_item(MODE_END, 0, 0, 0, 0, 0, 0);
		settle();
		// The open row stays open across a switch to replication.
		send_random_pixel(2, 0);
		settle();
		write_reg(gbd_pkg::REG_SCALE_X, 4096);
		write_reg(gbd_pkg::REG_SCALE_Y, 4096);
		send_random_pixel(1, 1);
		settle();
		write_reg(gbd_pkg::REG_SCALE_X, 0);
		write_reg(gbd_pkg::REG_SCALE_Y, 0);
		send_random_pixel(4095, 4095);
		send_item(MODE_END, 1, 1, 1, 1, 1, 1);
		settle();
		// Width zero accumulates nothing.
		write_reg(gbd_pkg::REG_DEST_WIDTH, 0);
		send_random_pixel(0, 0);
		send_item(MODE_END, 0, 0, 0, 0, 0, 0);
		settle();
	endtask

	// A single column fed many times in one row.
	task automatic test_single_column();
		configure(0, 0, 1, 1, 1);
		for (int i = 0; i < 40; i++)
			send_random_pixel(0, 0);
		send_item(MODE_END, 0, 0, 0, 0, 0, 0);
		settle();
	endtask

	function automatic int unsigned pick_scale(bit down);
		case ($urandom_range(0, 3))
			0: return down ? 0 : 32768;
			1: return down ? 4091 : 4092;
			default: return down ? $urandom_range(1, 4091) : $urandom_range(4092, 65535);
		endcase
	endfunction

	// Random images in raster order with some stray pixels and stray ends.
	task automatic test_random_images(int phases);
		int unsigned w, h, bx, by, dw;
		bit down;
		for (int p = 0; p < phases; p++) begin
			if (p == phases - 1)
				no_idle = 1'b1;
			down = $urandom_range(0, 2) != 0;
			case ($urandom_range(0, 4))
				0: dw = 0;
				1: dw = 1;
				2: dw = 64;
				3: dw = 127;
				default: dw = $urandom_range(1, 127);
			endcase
			configure($urandom_range(0, 4095), $urandom_range(0, 4095), dw,
				pick_scale(down), down ? $urandom_range(0, 65535) : pick_scale(1'b0));
			w = down ? $urandom_range(1, 24) : $urandom_range(1, 6);
			h = down ? $urandom_range(1, 4) : $urandom_range(1, 4);
			bx = ($urandom_range(0, 3) == 0) ? 4096 - w : $urandom_range(0, 64);
			by = ($urandom_range(0, 3) == 0) ? 4096 - h : $urandom_range(0, 64);
			for (int yy = 0; yy < h; yy++)
				for (int xx = 0; xx < w; xx++) begin
					if ($urandom_range(0, 19) == 0)
						send_item(MODE_END, $urandom_range(0, 4095), $urandom_range(0, 4095),
							$urandom_range(0, 255), $urandom_range(0, 255),
							$urandom_range(0, 255), $urandom_range(0, 255));
					else if ($urandom_range(0, 19) == 0)
						send_random_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
					else
						send_random_pixel(bx + xx, by + yy);
				end
			send_item(MODE_END, 0, 0, 0, 0, 0, 0);
			settle();
		end
	endtask

	// Output stall comes in random bursts while idling is allowed.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (no_idle) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				out_stall <= 1'($urandom_range(0, 1));
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// Checks every accepted draw against the oldest expectation; counts idle cycles.
	always @(posedge clk) begin
		draw_t e;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("tb_gray_box_downscaler_top: errors");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (draw_q.size() == 0) begin
					$error("unexpected draw x=%0d y=%0d gray=%0d", screen_x, screen_y, gray);
					errors++;
				end else begin
					e = draw_q.pop_front();
					if (screen_x !== e.x) begin
						$error("screen_x expected %0d actual %0d", e.x, screen_x);
						errors++;
					end
					if (screen_y !== e.y) begin
						$error("screen_y expected %0d actual %0d", e.y, screen_y);
						errors++;
					end
					if (gray !== e.g) begin
						$error("gray expected %0d actual %0d", e.g, gray);
						errors++;
					end
					if (last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, last);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		no_idle = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PIXEL;
		src_x = '0;
		src_y = '0;
		red = '0;
		green = '0;
		blue = '0;
		alpha = '0;
		cfg_valid = 1'b0;
		cfg_index = gbd_pkg::REG_ORIGIN_X;
		cfg_data = '0;
		m_origin_x = 0;
		m_origin_y = 0;
		m_dest_width = 64;
		m_scale_x = 4096;
		m_scale_y = 4096;
		row_open = 1'b0;
		open_row = 0;
		foreach (col_sum[i]) begin
			col_sum[i] = 0;
			col_cnt[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_replicate_scales();
		test_downscale();
		test_single_column();
		test_random_images(14);

		if (draw_q.size() != 0)
			$error("%0d expected draws never arrived", draw_q.size());
		if (errors == 0 && draw_q.size() == 0)
			$display("tb_gray_box_downscaler_top: clean");
		else
			$display("tb_gray_box_downscaler_top: errors");
		$finish;
	end

endmodule
